@@ hdl/hslt_pkg.sv @@
// Shared types, codes and helper functions for the heard source LRU table.
package hslt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic [2:0] ST_FILTERED = 3'd0;
  localparam logic [2:0] ST_BADCALL  = 3'd1;
  localparam logic [2:0] ST_HIT      = 3'd2;
  localparam logic [2:0] ST_NEW      = 3'd3;
  localparam logic [2:0] ST_REPLACED = 3'd4;

  localparam logic [1:0] CL_FILT = 2'd0;
  localparam logic [1:0] CL_BAD  = 2'd1;
  localparam logic [1:0] CL_OK   = 2'd2;

  localparam logic [1:0] REG_LOG_EN  = 2'd0;
  localparam logic [1:0] REG_MAX_ENT = 2'd1;

  localparam logic [55:0] CALL_MASK = 56'hFFFFFFFFFFFF1E;
  localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF;

  typedef struct packed {
    logic [1:0]  cls;
    logic [3:0]  iface;
    logic [15:0] group;
    logic [55:0] call;
    logic [31:0] now;
  } hslt_item_t;

  typedef struct packed {
    logic [55:0] call;
    logic [3:0]  iface;
    logic [15:0] group;
    logic [31:0] count;
    logic [31:0] tm;
  } hslt_entry_t;

  typedef struct packed {
    logic       lim_we;
    logic [6:0] lim_val;
  } hslt_cfg_t;

  function automatic logic char_ok(input logic [6:0] c);
    char_ok = (c >= 7'd65 && c <= 7'd90) || (c >= 7'd48 && c <= 7'd57) || (c == 7'd32);
  endfunction

  function automatic logic call_valid(input logic [55:0] call);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 6; i++) begin
      ok = ok & char_ok(call[55 - 8*i -: 7]);
    end
    call_valid = ok;
  endfunction

endpackage

@@ hdl/heard_source_lru_table_top.sv @@
// Top level of the heard source LRU table: configuration registers, front end and back end.
//
// Usage: heard frames enter on the in_ channel (valid/stall); each produces exactly
// one result transaction on the out_ channel, in order. The cfg_ port writes the
// logging enable (index 0) and the capacity limit (index 1); the user must write them
// only while the block is idle, which the block itself does not enforce. A filtered
// frame or a bad callsign is answered from the queue without a table search.
// A logged frame walks the recency list through a pipelined search of the rank and
// entry memories (one position per cycle), then moves the touched slot to the front
// with one rank memory step per position, and only then takes the next frame.
// Two frames may wait in the queue between the front and back ends.
// Reset is synchronous and empties the table; no clearing pass is needed.
// When the receiver stalls, the result is held in the output register, the back
// end stops, and in_stall rises once the queue is full.
module heard_source_lru_table_top
  import hslt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_iface_id,
  input  logic        in_iface_log_enable,
  input  logic [15:0] in_heard_group,
  input  logic [55:0] in_callsign,
  input  logic [31:0] in_now_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [5:0]  out_slot,
  output logic [31:0] out_heard_count
);

  logic       log_en_r, log_en_nxt;
  logic [6:0] max_r, max_nxt;
  hslt_cfg_t  cfg;
  logic       q_pop, q_valid;
  hslt_item_t q_item;

  always_comb begin
    log_en_nxt  = log_en_r;
    max_nxt     = max_r;
    cfg.lim_we  = 1'b0;
    cfg.lim_val = cfg_wdata;
    if (cfg_we) begin
      case (cfg_index)
        REG_LOG_EN: begin
          log_en_nxt = cfg_wdata[0];
        end
        REG_MAX_ENT: begin
          max_nxt    = cfg_wdata;
          cfg.lim_we = 1'b1;
        end
        default: begin
          max_nxt = max_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_en_r <= 1'b1;
      max_r    <= 7'd0;
    end else begin
      log_en_r <= log_en_nxt;
      max_r    <= max_nxt;
    end
  end

  hslt_front u_front (
    .clk(clk), .rst_n(rst_n), .log_en(log_en_r),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_iface_id(in_iface_id), .in_iface_log_enable(in_iface_log_enable),
    .in_heard_group(in_heard_group), .in_callsign(in_callsign),
    .in_now_time(in_now_time),
    .q_pop(q_pop), .q_valid(q_valid), .q_item(q_item)
  );

  hslt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .max_entries(max_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_slot(out_slot), .out_heard_count(out_heard_count)
  );

endmodule

@@ hdl/hslt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hslt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/hslt_front.sv @@
// Front end: accepts heard frames, filters and validates them, and queues them.
module hslt_front
  import hslt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        log_en,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_iface_id,
  input  logic        in_iface_log_enable,
  input  logic [15:0] in_heard_group,
  input  logic [55:0] in_callsign,
  input  logic [31:0] in_now_time,
  input  logic        q_pop,
  output logic        q_valid,
  output hslt_item_t  q_item
);

  hslt_item_t q_mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  hslt_item_t item;

  always_comb begin
    item.iface = in_iface_id;
    item.group = in_heard_group;
    item.call  = in_callsign;
    item.now   = in_now_time;
    if (!(log_en && in_iface_log_enable)) begin
      item.cls = CL_FILT;
    end else if (!call_valid(in_callsign)) begin
      item.cls = CL_BAD;
    end else begin
      item.cls = CL_OK;
    end
  end

  assign in_stall = cnt_r[1];
  assign push     = in_valid && !cnt_r[1];
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_mem_r[wp_r] <= item;
    end
  end

endmodule

@@ hdl/hslt_back.sv @@
// Back end: searches the table in recency order and moves the touched entry to the front.
module hslt_back
  import hslt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  hslt_cfg_t   cfg,
  input  logic [6:0]  max_entries,
  input  logic        q_valid,
  input  hslt_item_t  q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [5:0]  out_slot,
  output logic [31:0] out_heard_count
);

  localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(hslt_entry_t);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_MISS  = 3'd2;
  localparam logic [2:0] S_MWAIT = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  function automatic logic [CW-1:0] lim_of(input logic [6:0] me);
    if (me == 7'd0 || 32'(me) > TABLE_DEPTH) begin
      lim_of = CW'(TABLE_DEPTH);
    end else begin
      lim_of = CW'(me);
    end
  endfunction

  logic [2:0]   state_r, state_nxt;
  hslt_item_t   item_r, item_nxt;
  logic [CW-1:0] ec_r, ec_nxt, hw_r, hw_nxt;
  logic [CW-1:0] ip_r, ip_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  logic         v1_r, v1_nxt, v2_r, v2_nxt;
  logic [SW-1:0] s2_r, s2_nxt;
  logic [CW-1:0] pos_r, pos_nxt, rp_r, rp_nxt;
  logic [SW-1:0] slot_r, slot_nxt, wp_r, wp_nxt;
  logic         wv_r, wv_nxt;
  logic [2:0]   st_r, st_nxt;
  hslt_entry_t  ent_r, ent_nxt;
  logic [SW-1:0] rq_r;
  logic         ov_r, ov_nxt;
  logic [2:0]   os_r, os_nxt;
  logic [5:0]   osl_r, osl_nxt;
  logic [31:0]  oc_r, oc_nxt;

  logic [SW-1:0] rk_raddr, rk_waddr, rk_wdata, rk_q, rank_rd;
  logic          rk_we;
  logic [SW-1:0] en_raddr;
  logic [EW-1:0] en_q;
  logic          en_we;
  hslt_entry_t   en_wdata, ent_q;
  logic          match;
  logic [CW-1:0] lim;
  logic [31:0]   new_cnt;

  hslt_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_rank (
    .clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
    .raddr(rk_raddr), .rdata(rk_q)
  );

  hslt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_entry (
    .clk(clk), .we(en_we), .waddr(slot_r), .wdata(en_wdata),
    .raddr(en_raddr), .rdata(en_q)
  );

  assign ent_q   = en_q;
  assign rank_rd = (CW'(rq_r) >= hw_r) ? rq_r : rk_q;
  assign match   = (ent_q.iface == item_r.iface) && (ent_q.group == item_r.group) &&
                   (((ent_q.call ^ item_r.call) & CALL_MASK) == 56'd0);
  assign lim     = lim_of(max_entries);
  assign new_cnt = (ent_r.count == COUNT_MAX) ? COUNT_MAX : ent_r.count + 32'd1;

  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_slot        = osl_r;
  assign out_heard_count = oc_r;

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    ec_nxt    = ec_r;
    hw_nxt    = hw_r;
    ip_nxt    = ip_r;
    p1_nxt    = p1_r;
    p2_nxt    = p1_r;
    v1_nxt    = 1'b0;
    v2_nxt    = 1'b0;
    s2_nxt    = rank_rd;
    pos_nxt   = pos_r;
    rp_nxt    = rp_r;
    slot_nxt  = slot_r;
    wp_nxt    = wp_r;
    wv_nxt    = 1'b0;
    st_nxt    = st_r;
    ent_nxt   = ent_r;
    ov_nxt    = ov_r && out_stall;
    os_nxt    = os_r;
    osl_nxt   = osl_r;
    oc_nxt    = oc_r;
    q_pop     = 1'b0;
    rk_raddr  = rq_r;
    rk_we     = 1'b0;
    rk_waddr  = wp_r;
    rk_wdata  = rank_rd;
    en_raddr  = rank_rd;
    en_we     = 1'b0;
    en_wdata  = ent_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid && !ov_r) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          ip_nxt   = '0;
          if (q_item.cls == CL_FILT || q_item.cls == CL_BAD) begin
            ov_nxt  = 1'b1;
            os_nxt  = (q_item.cls == CL_FILT) ? ST_FILTERED : ST_BADCALL;
            osl_nxt = 6'd0;
            oc_nxt  = 32'd0;
          end else if (ec_r == '0) begin
            state_nxt = S_MISS;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (ip_r < ec_r) begin
          rk_raddr = ip_r[SW-1:0];
          v1_nxt   = 1'b1;
          p1_nxt   = ip_r;
          ip_nxt   = ip_r + CW'(1);
        end
        v2_nxt = v1_r;
        if (v2_r) begin
          if (match) begin
            pos_nxt   = p2_r;
            rp_nxt    = p2_r;
            slot_nxt  = s2_r;
            ent_nxt   = ent_q;
            st_nxt    = ST_HIT;
            state_nxt = S_SHIFT;
          end else if (p2_r == ec_r - CW'(1)) begin
            state_nxt = S_MISS;
          end
        end
      end
      S_MISS: begin
        if (ec_r >= lim) begin
          pos_nxt = ec_r - CW'(1);
          st_nxt  = ST_REPLACED;
        end else begin
          pos_nxt = ec_r;
          ec_nxt  = ec_r + CW'(1);
          st_nxt  = ST_NEW;
        end
        rk_raddr  = pos_nxt[SW-1:0];
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        slot_nxt      = rank_rd;
        rp_nxt        = pos_r;
        ent_nxt.call  = item_r.call;
        ent_nxt.iface = item_r.iface;
        ent_nxt.group = item_r.group;
        ent_nxt.count = 32'd0;
        ent_nxt.tm    = item_r.now;
        state_nxt     = S_SHIFT;
      end
      S_SHIFT: begin
        if (rp_r != '0) begin
          rk_raddr = SW'(rp_r - CW'(1));
          wv_nxt   = 1'b1;
          wp_nxt   = SW'(rp_r);
          rp_nxt   = rp_r - CW'(1);
        end
        if (wv_r) begin
          rk_we = 1'b1;
        end
        if (rp_r == '0 && !wv_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        rk_we          = 1'b1;
        rk_waddr       = '0;
        rk_wdata       = slot_r;
        en_we          = 1'b1;
        en_wdata.count = new_cnt;
        en_wdata.tm    = item_r.now;
        if (pos_r + CW'(1) > hw_r) begin
          hw_nxt = pos_r + CW'(1);
        end
        ov_nxt    = 1'b1;
        os_nxt    = st_r;
        osl_nxt   = 6'(slot_r);
        oc_nxt    = new_cnt;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg.lim_we && ec_r > lim_of(cfg.lim_val)) begin
      ec_nxt = lim_of(cfg.lim_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ec_r    <= '0;
      hw_r    <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      wv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ec_r    <= ec_nxt;
      hw_r    <= hw_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
      wv_r    <= wv_nxt;
      ov_r    <= ov_nxt;
    end
    item_r <= item_nxt;
    ip_r   <= ip_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    s2_r   <= s2_nxt;
    pos_r  <= pos_nxt;
    rp_r   <= rp_nxt;
    slot_r <= slot_nxt;
    wp_r   <= wp_nxt;
    st_r   <= st_nxt;
    ent_r  <= ent_nxt;
    rq_r   <= rk_raddr;
    os_r   <= os_nxt;
    osl_r  <= osl_nxt;
    oc_r   <= oc_nxt;
  end

endmodule
